/* rtl/core/isb_pkg.sv */
// isb_pkg: shared types and constants for the indexed sequence buffer
// no dependencies; imported by isb_cell and indexed_sequence_buffer
package isb_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CAPACITY = 16;
    localparam int GROUP    = 16;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // broadcast control that every cell sees in the same cycle
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              rd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } t_cell_ctl;

endpackage

/* rtl/core/indexed_sequence_buffer.sv */
// indexed_sequence_buffer: ordered list of signed words held in a chain of cells
// a taken word passes the execute and reduce states; o_done and the result register as reduce ends
// no new word is taken until the last one is through; busy covers the shift and read-gather steps
// insert and delete shift all cells at or past the position together; reads gather through a 2-level tree
// reset: count cleared to zero, cell contents undefined and never read before written
// depends on isb_pkg and isb_cell
module indexed_sequence_buffer
    import isb_pkg::*;
#(
    parameter int P_CAPACITY = CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value_in,
    output logic                     o_done,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [POS_W-1:0]         o_count_out
);

    localparam int CNT_W = $clog2(P_CAPACITY + 1);
    localparam int NG    = (P_CAPACITY + GROUP - 1) / GROUP;
    localparam int NTAP  = NG * GROUP;

    // control sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_REDUCE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [STAT_W-1:0] r_stat;
    logic              r_apply;   // insert/delete that changes the list
    logic              r_rd_ok;   // read of a live entry
    logic              r_rd_err;  // read past the end returns all ones

    logic [STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0] r_out_value;
    logic              r_done;

    logic              w_accept;
    logic [POS_W-1:0]  w_count8;
    logic [STAT_W-1:0] w_stat;
    logic              w_apply;
    logic              w_rd_ok;
    logic              w_rd_err;

    t_cell_ctl         w_ctl;
    logic [DATA_W-1:0] w_entry [P_CAPACITY];
    logic [DATA_W-1:0] w_tap   [NTAP];
    logic [DATA_W-1:0] w_grp   [NG];
    logic [DATA_W-1:0] r_grp   [NG];
    logic [DATA_W-1:0] w_gather;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign w_count8 = POS_W'(r_count);

    // range and full checks are made as the word is taken
    always_comb begin
        w_stat   = STAT_OK;
        w_apply  = 1'b0;
        w_rd_ok  = 1'b0;
        w_rd_err = 1'b0;
        case (i_kind)
            KIND_INSERT: begin
                if (i_position > w_count8) begin
                    w_stat = STAT_RANGE;
                end else if (r_count >= CNT_W'(P_CAPACITY)) begin
                    w_stat = STAT_FULL;
                end else begin
                    w_apply = 1'b1;
                end
            end
            KIND_DELETE: begin
                if (i_position >= w_count8) begin
                    w_stat = STAT_RANGE;
                end else begin
                    w_apply = 1'b1;
                end
            end
            KIND_READ: begin
                if (i_position >= w_count8) begin
                    w_stat   = STAT_RANGE;
                    w_rd_err = 1'b1;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            default: begin
                // unused kind: no change, ok status
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_kind;
            r_pos    <= i_position;
            r_val    <= i_value_in;
            r_stat   <= w_stat;
            r_apply  <= w_apply;
            r_rd_ok  <= w_rd_ok;
            r_rd_err <= w_rd_err;
        end
    end

    // broadcast to the cells only during the execute cycle
    always_comb begin
        w_ctl.ins = (r_state == ST_EXEC) && r_apply && (r_kind == KIND_INSERT);
        w_ctl.del = (r_state == ST_EXEC) && r_apply && (r_kind == KIND_DELETE);
        w_ctl.rd  = (r_state == ST_EXEC) && r_rd_ok;
        w_ctl.pos = r_pos;
        w_ctl.val = r_val;
    end

    // chain of cells; each takes its left neighbor on insert, right on delete
    for (genvar i = 0; i < P_CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[i-1];
        end
        if (i == P_CAPACITY - 1) begin : g_last
            assign w_right = w_entry[i];
        end else begin : g_mid_r
            assign w_right = w_entry[i+1];
        end
        isb_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[i]),
            .o_tap   (w_tap[i])
        );
    end

    // pad taps so groups are full width
    for (genvar i = P_CAPACITY; i < NTAP; i++) begin : g_pad
        assign w_tap[i] = '0;
    end

    // first gather level: one-hot or within each group of cells
    for (genvar g = 0; g < NG; g++) begin : g_group
        always_comb begin
            w_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                w_grp[g] = w_grp[g] | w_tap[g*GROUP + k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (r_state == ST_EXEC) begin
                r_grp[g] <= w_grp[g];
            end
        end
    end

    // second gather level across the group registers
    always_comb begin
        w_gather = '0;
        for (int g = 0; g < NG; g++) begin
            w_gather = w_gather | r_grp[g];
        end
    end

    // sequencer and count
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_REDUCE;
                if (r_apply && (r_kind == KIND_INSERT)) begin
                    n_count = r_count + CNT_W'(1);
                end else if (r_apply && (r_kind == KIND_DELETE)) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ST_REDUCE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == ST_REDUCE);
        end
    end

    // result word registered and held until the next result is registered
    always_ff @(posedge i_clk) begin
        if (r_state == ST_REDUCE) begin
            r_out_status <= r_stat;
            if (r_rd_err) begin
                r_out_value <= '1;
            end else if (r_rd_ok) begin
                r_out_value <= w_gather;
            end else begin
                r_out_value <= '0;
            end
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_out_status;
    assign o_value_out = r_out_value;
    assign o_count_out = w_count8;

endmodule

/* rtl/core/isb_cell.sv */
// isb_cell: one entry of the sequence, shifts with its neighbors
// depends on isb_pkg (t_cell_ctl, widths)
module isb_cell
    import isb_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_entry,
    output logic [DATA_W-1:0] o_tap
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (MY_POS == i_ctl.pos) begin
                n_entry = i_ctl.val;
            end else if (MY_POS > i_ctl.pos) begin
                n_entry = i_left;
            end
        end else if (i_ctl.del) begin
            if (MY_POS >= i_ctl.pos) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = (i_ctl.rd && (MY_POS == i_ctl.pos)) ? r_entry : '0;

endmodule
